// File: rtl/core/mtd_pkg.sv
// mtd_pkg: shared constants, types and helpers for the morse tree decoder
// used by mtd_node_table and morse_tree_decoder; no dependencies
package mtd_pkg;

    // tree geometry
    localparam int TABLE_DEPTH      = 128;
    localparam int POS_W            = $clog2(TABLE_DEPTH);
    localparam int ROW_W            = POS_W - 1;
    localparam int ROWS             = TABLE_DEPTH / 2;
    localparam int CHAR_W           = 8;
    localparam int MAX_CODE_SYMBOLS = 6;
    localparam int DEPTH_W          = $clog2(MAX_CODE_SYMBOLS + 1);

    // character codes
    localparam logic [CHAR_W-1:0] DOT_CHAR   = 8'h2E;
    localparam logic [CHAR_W-1:0] ROOT_CHAR  = 8'h20;
    localparam logic [CHAR_W-1:0] TAB_CHAR   = 8'h09;
    localparam logic [CHAR_W-1:0] CR_CHAR    = 8'h0D;

    // operation codes
    localparam logic OP_DECODE = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    localparam logic [POS_W-1:0] ROOT_POS = POS_W'(1);

    // table write request
    typedef struct packed {
        logic              en;
        logic [POS_W-1:0]  index;
        logic [CHAR_W-1:0] value;
    } tbl_wr_t;

    typedef logic [1:0][CHAR_W-1:0] child_pair_t;

    // whitespace: space, or tab through carriage return
    function automatic logic is_separator(input logic [CHAR_W-1:0] c);
        logic sep;
        sep = (c == ROOT_CHAR) || ((c >= TAB_CHAR) && (c <= CR_CHAR));
        return sep;
    endfunction

endpackage

// File: rtl/core/morse_tree_decoder.sv
// morse_tree_decoder: top level of the heap-indexed morse decoder
// uses mtd_pkg and mtd_node_table
// a result is registered on the input transfer that causes it, shown the next cycle
// throughput: one item per cycle while the output is not stalled; the node table read
// of both children of the next position, registered each cycle, sets this figure
// reset: position at the root, no discard in progress, every table node reads as absent
module morse_tree_decoder (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       operation,
    input  logic [mtd_pkg::CHAR_W-1:0] code_char,
    input  logic                       message_end,
    input  logic [mtd_pkg::POS_W-1:0]  entry_index,
    input  logic [mtd_pkg::CHAR_W-1:0] entry_value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [mtd_pkg::CHAR_W-1:0] decoded_char,
    output logic                       invalid_code,
    output logic                       last_of_message
);
    import mtd_pkg::*;

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic               disc_reg, disc_next;
    logic [CHAR_W-1:0]  cur_char_reg, cur_char_next;

    logic               out_valid_reg;
    logic [CHAR_W-1:0]  out_char_reg;
    logic               out_inv_reg;
    logic               out_last_reg;

    logic               xfer_in;
    logic               is_dec;
    logic               is_wr;
    tbl_wr_t            wr;
    child_pair_t        child;
    logic               sep;
    logic               dir;
    logic [POS_W:0]     next_pos;
    logic [CHAR_W-1:0]  child_val;
    logic               bad;
    logic [CHAR_W-1:0]  here_char;

    logic               res_valid;
    logic [CHAR_W-1:0]  res_char;
    logic               res_inv;
    logic               res_last;

    // handshake
    assign in_ready = !out_valid_reg || out_ready;
    assign xfer_in  = in_valid && in_ready;
    assign is_dec   = xfer_in && (operation == OP_DECODE);
    assign is_wr    = xfer_in && (operation == OP_WRITE);

    assign wr.en    = is_wr;
    assign wr.index = entry_index;
    assign wr.value = entry_value;

    mtd_node_table u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (wr),
        .rd_row (pos_next[ROW_W-1:0]),
        .child  (child)
    );

    // tree step
    assign sep       = is_separator(code_char);
    assign dir       = (code_char != DOT_CHAR);
    assign next_pos  = {pos_reg, dir};
    assign child_val = child[dir];
    assign bad       = (depth_reg >= DEPTH_W'(MAX_CODE_SYMBOLS)) || next_pos[POS_W]
                       || (child_val == '0);
    assign here_char = (pos_reg == ROOT_POS) ? ROOT_CHAR : cur_char_reg;

    always_comb
    begin
        pos_next      = pos_reg;
        depth_next    = depth_reg;
        disc_next     = disc_reg;
        cur_char_next = cur_char_reg;
        res_valid     = 1'b0;
        res_char      = '0;
        res_inv       = 1'b0;
        res_last      = 1'b0;
        priority if (is_wr)
        begin
            // a write to the current node changes what a separator emits there, except at the root
            if (entry_index == pos_reg)
                cur_char_next = entry_value;
        end
        else if (is_dec && disc_reg)
        begin
            if (message_end)
                disc_next = 1'b0;
        end
        else if (is_dec && sep)
        begin
            res_valid  = 1'b1;
            res_char   = here_char;
            res_last   = message_end;
            pos_next   = ROOT_POS;
            depth_next = '0;
        end
        else if (is_dec && bad)
        begin
            res_valid  = 1'b1;
            res_inv    = 1'b1;
            res_last   = 1'b1;
            pos_next   = ROOT_POS;
            depth_next = '0;
            disc_next  = !message_end;
        end
        else if (is_dec)
        begin
            cur_char_next = child_val;
            if (message_end)
            begin
                res_valid  = 1'b1;
                res_char   = child_val;
                res_last   = 1'b1;
                pos_next   = ROOT_POS;
                depth_next = '0;
            end
            else
            begin
                pos_next   = next_pos[POS_W-1:0];
                depth_next = depth_reg + 1'b1;
            end
        end
        else
        begin
            pos_next = pos_reg;
        end
    end

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= ROOT_POS;
            depth_reg     <= '0;
            disc_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            depth_reg <= depth_next;
            disc_reg  <= disc_next;
            if (xfer_in && res_valid)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        cur_char_reg <= cur_char_next;
        if (xfer_in && res_valid)
        begin
            out_char_reg <= res_char;
            out_inv_reg  <= res_inv;
            out_last_reg <= res_last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign decoded_char    = out_char_reg;
    assign invalid_code    = out_inv_reg;
    assign last_of_message = out_last_reg;

    a_disc_at_root: assert property (@(posedge clk) disable iff (!rst_n)
        disc_reg |-> (pos_reg == ROOT_POS))
        else $error("discarding away from the root");

    a_depth_tracks_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (depth_reg == '0) == (pos_reg == ROOT_POS))
        else $error("depth counter out of step with tree position");

    a_error_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && invalid_code) |-> ((decoded_char == '0) && last_of_message))
        else $error("error result with character or without message end");

    a_write_keeps_pos: assert property (@(posedge clk) disable iff (!rst_n)
        is_wr |=> ($stable(pos_reg) && $stable(disc_reg)))
        else $error("table write moved the decoder");

endmodule

// File: rtl/core/mtd_node_table.sv
// mtd_node_table: decode tree storage, one row per parent node holding both children
// registered row read with per-entry valid bits and a same-row write bypass; uses mtd_pkg
module mtd_node_table (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mtd_pkg::tbl_wr_t          wr,
    input  logic [mtd_pkg::ROW_W-1:0] rd_row,
    output mtd_pkg::child_pair_t      child
);
    import mtd_pkg::*;

    child_pair_t       mem [ROWS];
    child_pair_t       mem_rd_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [1:0]        vld_rd_reg;
    logic [1:0]        byp_hit_reg;
    logic [1:0]        byp_hit_next;
    logic [CHAR_W-1:0] byp_val_reg;
    logic [ROW_W-1:0]  wr_row;

    assign wr_row = wr.index[POS_W-1:1];

    // memory write and registered row read
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_row][wr.index[0]] <= wr.value;
        end
        mem_rd_reg  <= mem[rd_row];
        byp_val_reg <= wr.value;
    end

    // write bypass for the row being read this cycle
    always_comb
    begin
        byp_hit_next[0] = wr.en && (wr_row == rd_row) && !wr.index[0];
        byp_hit_next[1] = wr.en && (wr_row == rd_row) && wr.index[0];
    end

    // valid bits, cleared by reset so unwritten nodes read as absent
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            vld_rd_reg  <= '0;
            byp_hit_reg <= '0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.index] <= 1'b1;
            end
            vld_rd_reg  <= {valid_reg[{rd_row, 1'b1}], valid_reg[{rd_row, 1'b0}]};
            byp_hit_reg <= byp_hit_next;
        end
    end

    // effective child values
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            if (byp_hit_reg[l])
                child[l] = byp_val_reg;
            else if (vld_rd_reg[l])
                child[l] = mem_rd_reg[l];
            else
                child[l] = '0;
        end
    end

    // bypass only follows an actual write
    a_byp_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        (byp_hit_reg != 2'b00) |-> $past(wr.en))
        else $error("bypass hit without a preceding table write");

endmodule
